### src/assert_macros.svh
// Assertion macros shared by the scheduler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, switched off while reset is asserted
`define PPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included
`define PPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/pps_pkg.sv
// Package: sizes, scan candidate type and control states of the priority scheduler
package pps_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int IDX_W         = $clog2(MAX_PROCESSES);
  localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
  localparam int PC_W          = 5;
  localparam int ENTRY_W       = 4;
  localparam int ARR_W         = 16;
  localparam int BURST_W       = 16;
  localparam int PRIO_W        = 8;
  localparam int TIME_W        = 20;
  localparam int CMPC_W        = (CNT_W > PC_W) ? CNT_W : PC_W;
  localparam int CMPI_W        = (IDX_W > ENTRY_W) ? IDX_W : ENTRY_W;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [PC_W-1:0]   PC_RESET = PC_W'(16);

  // Work count, saturating at two or more
  typedef enum logic [1:0] {
    WC_NONE = 2'd0,
    WC_ONE  = 2'd1,
    WC_MANY = 2'd2
  } wcnt_t;

  // Best candidate so far, handed from cell to cell during a scan
  typedef struct packed {
    logic               found;
    wcnt_t              wcnt;
    logic [IDX_W-1:0]   idx;
    logic [PRIO_W-1:0]  prio;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic               rem_one;
  } cand_t;

  // Item function codes
  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TICK = 1'b1
  } func_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_APPLY = 2'd2,
    ST_EMIT  = 2'd3
  } state_t;

endpackage

### src/pps_if.sv
// Channel interfaces: input items, result items and the configuration write
interface pps_in_if;
  import pps_pkg::*;
  logic                valid;
  logic                ready;
  logic                func;
  logic [ENTRY_W-1:0]  entry_index;
  logic [ARR_W-1:0]    arrival_time;
  logic [BURST_W-1:0]  burst_length;
  logic [PRIO_W-1:0]   priority_level;
  modport source (output valid, func, entry_index, arrival_time, burst_length,
                  priority_level, input ready);
  modport sink   (input valid, func, entry_index, arrival_time, burst_length,
                  priority_level, output ready);
endinterface

interface pps_out_if;
  import pps_pkg::*;
  logic               valid;
  logic               ready;
  logic               ran_valid;
  logic [ENTRY_W-1:0] ran_index;
  logic               finished;
  logic [TIME_W-1:0]  turnaround;
  logic [TIME_W-1:0]  waiting;
  logic               all_done;
  logic [TIME_W-1:0]  time_now;
  modport source (output valid, ran_valid, ran_index, finished, turnaround, waiting,
                  all_done, time_now, input ready);
  modport sink   (input valid, ran_valid, ran_index, finished, turnaround, waiting,
                  all_done, time_now, output ready);
endinterface

interface pps_cfg_if;
  import pps_pkg::*;
  logic            valid;
  logic            ready;
  logic [PC_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### src/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: control sequencer and chain of entry cells
//
//   channel  | direction | carries
//   ---------+-----------+-----------------------------------------------------
//   in_ch    | in        | func, entry_index, arrival_time, burst_length, priority
//   out_ch   | out       | ran_valid, ran_index, finished, turnaround, waiting,
//            |           | all_done, time_now
//   cfg_ch   | in        | process_count (always ready)
//
// Each item is taken in the idle state, then scanned while the token walks the cell chain,
// then passes through the apply state and the emit state.
// A new item is taken only when the sequencer is idle. A result waiting on out_ch does not
// block the next item; that item holds in its emit cycle until the waiting result is taken.
// Synchronous active-low reset clears all work, time and the count (to 16); no sweep.
module preemptive_priority_scheduler
  import pps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  pps_in_if.sink    in_ch,
  pps_out_if.source out_ch,
  pps_cfg_if.sink   cfg_ch
);

`include "assert_macros.svh"

  state_t              state_r;
  state_t              state_nxt;
  logic [PC_W-1:0]     pc_r;
  logic [CNT_W-1:0]    n_eff;
  logic [TIME_W-1:0]   time_r;
  logic [TIME_W-1:0]   time_nxt;
  logic                func_r;
  logic                start_r;
  logic                accept;
  logic                tok_last;
  logic                apply_en;
  logic                emit_en;
  logic                dec_en;
  logic                advance;
  logic                finish;
  logic                ran_r;
  logic [ENTRY_W-1:0]  idx_r;
  logic                fin_r;
  logic [TIME_W-1:0]   tat_r;
  logic [BURST_W-1:0]  burst_r;
  logic                done_r;
  logic [TIME_W-1:0]   wait_val;
  logic                out_valid_r;
  logic                out_ran_r;
  logic [ENTRY_W-1:0]  out_idx_r;
  logic                out_fin_r;
  logic [TIME_W-1:0]   out_tat_r;
  logic [TIME_W-1:0]   out_wait_r;
  logic                out_done_r;
  logic [TIME_W-1:0]   out_time_r;
  logic [MAX_PROCESSES-1:0] wr_vec;
  logic [MAX_PROCESSES-1:0] dec_vec;
  logic [MAX_PROCESSES:0]   tok_chain;
  cand_t               cand_chain [MAX_PROCESSES+1];
  cand_t               best;

  // Configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_RESET;
    end else if (cfg_ch.valid) begin
      pc_r <= cfg_ch.data;
    end
  end

  // Clamp count to the entries present
  assign n_eff = (CMPC_W'(pc_r) > CMPC_W'(MAX_PROCESSES)) ? CNT_W'(MAX_PROCESSES)
                                                           : CNT_W'(pc_r);

  assign accept   = in_ch.valid && in_ch.ready;
  assign tok_last = tok_chain[MAX_PROCESSES];
  assign best     = cand_chain[MAX_PROCESSES];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_SCAN;
      ST_SCAN:  if (tok_last) state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_EMIT;
      ST_EMIT:  if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    apply_en    = 1'b0;
    emit_en     = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_SCAN:  ;
      ST_APPLY: apply_en = 1'b1;
      ST_EMIT:  emit_en = !out_valid_r || out_ch.ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_ch.func;
    end
  end

  // Chain of entry cells, scan enters at cell zero
  assign cand_chain[0] = '0;
  assign tok_chain[0]  = start_r;
  assign dec_en        = apply_en && (func_r == FUNC_TICK) && best.found;

  for (genvar i = 0; i < MAX_PROCESSES; i++) begin : g_cell
    assign wr_vec[i]  = accept && (in_ch.func == FUNC_LOAD) &&
                        (CMPI_W'(in_ch.entry_index) == CMPI_W'(i));
    assign dec_vec[i] = dec_en && (best.idx == IDX_W'(i));

    pps_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (IDX_W'(i)),
      .n_eff      (n_eff),
      .time_now   (time_r),
      .wr_en      (wr_vec[i]),
      .wr_arrival (in_ch.arrival_time),
      .wr_burst   (in_ch.burst_length),
      .wr_prio    (in_ch.priority_level),
      .dec_en     (dec_vec[i]),
      .tok_in     (tok_chain[i]),
      .cand_in    (cand_chain[i]),
      .tok_out    (tok_chain[i+1]),
      .cand_out   (cand_chain[i+1])
    );
  end

  // Advance time on a run or an idle tick, saturating
  assign advance  = (func_r == FUNC_TICK) && (best.found || (best.wcnt != WC_NONE));
  assign time_nxt = (advance && (time_r != TIME_MAX)) ? time_r + TIME_W'(1) : time_r;
  assign finish   = dec_en && best.rem_one;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else if (apply_en) begin
      time_r <= time_nxt;
    end
  end

  // Capture the tick outcome
  always_ff @(posedge clk) begin
    if (apply_en) begin
      ran_r   <= dec_en;
      idx_r   <= dec_en ? ENTRY_W'(best.idx) : '0;
      fin_r   <= finish;
      tat_r   <= finish ? time_nxt - TIME_W'(best.arrival) : '0;
      burst_r <= best.burst;
      done_r  <= (best.wcnt == WC_NONE) || (finish && (best.wcnt == WC_ONE));
    end
  end

  // Waiting time, clamp at zero
  assign wait_val = (tat_r >= TIME_W'(burst_r)) ? tat_r - TIME_W'(burst_r) : '0;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      out_ran_r  <= ran_r;
      out_idx_r  <= idx_r;
      out_fin_r  <= fin_r;
      out_tat_r  <= tat_r;
      out_wait_r <= fin_r ? wait_val : '0;
      out_done_r <= done_r;
      out_time_r <= time_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ran_valid  = out_ran_r;
  assign out_ch.ran_index  = out_idx_r;
  assign out_ch.finished   = out_fin_r;
  assign out_ch.turnaround = out_tat_r;
  assign out_ch.waiting    = out_wait_r;
  assign out_ch.all_done   = out_done_r;
  assign out_ch.time_now   = out_time_r;

  // Checks
  `PPS_ASSERT(a_accept_starts_scan, clk, rst_n, accept |=> (state_r == ST_SCAN), "accepted item did not start a scan")
  `PPS_ASSERT(a_token_in_scan, clk, rst_n, tok_last |-> (state_r == ST_SCAN), "scan token left the chain outside a scan")
  `PPS_ASSERT(a_time_only_on_apply, clk, rst_n, (state_r != ST_APPLY) |=> $stable(time_r), "time moved outside the apply cycle")
  `PPS_ASSERT_ALWAYS(a_single_decrement, clk, $onehot0(dec_vec), "more than one entry charged in a tick")

endmodule

### src/pps_cell.sv
// One process entry of the scan chain: stores the entry and refines the passing candidate
module pps_cell
  import pps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [IDX_W-1:0]   cell_idx,
  input  logic [CNT_W-1:0]   n_eff,
  input  logic [TIME_W-1:0]  time_now,
  input  logic               wr_en,
  input  logic [ARR_W-1:0]   wr_arrival,
  input  logic [BURST_W-1:0] wr_burst,
  input  logic [PRIO_W-1:0]  wr_prio,
  input  logic               dec_en,
  input  logic               tok_in,
  input  cand_t              cand_in,
  output logic               tok_out,
  output cand_t              cand_out
);

  logic [ARR_W-1:0]   arrival_r;
  logic [BURST_W-1:0] burst_r;
  logic [PRIO_W-1:0]  prio_r;
  logic [BURST_W-1:0] rem_r;
  logic               tok_r;
  cand_t              cand_r;
  cand_t              cand_nxt;
  logic               active;
  logic               has_work;
  logic               eligible;

  // Entry takes part and still has work
  assign active   = CNT_W'(cell_idx) < n_eff;
  assign has_work = active && (rem_r != '0);
  assign eligible = has_work && (TIME_W'(arrival_r) <= time_now);

  // Refine candidate: later index wins a tie
  always_comb begin
    cand_nxt = cand_in;
    if (eligible && (!cand_in.found || (prio_r <= cand_in.prio))) begin
      cand_nxt.found   = 1'b1;
      cand_nxt.idx     = cell_idx;
      cand_nxt.prio    = prio_r;
      cand_nxt.arrival = arrival_r;
      cand_nxt.burst   = burst_r;
      cand_nxt.rem_one = (rem_r == BURST_W'(1));
    end
    if (has_work) begin
      unique case (cand_in.wcnt)
        WC_NONE: cand_nxt.wcnt = WC_ONE;
        WC_ONE:  cand_nxt.wcnt = WC_MANY;
        default: cand_nxt.wcnt = WC_MANY;
      endcase
    end
  end

  // Load entry, charge one tick of work
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (wr_en) begin
      rem_r <= wr_burst;
    end else if (dec_en) begin
      rem_r <= rem_r - BURST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      arrival_r <= wr_arrival;
      burst_r   <= wr_burst;
      prio_r    <= wr_prio;
    end
  end

  // Advance token, hold candidate between scans
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      cand_r <= cand_nxt;
    end
  end

  assign tok_out  = tok_r;
  assign cand_out = cand_r;

endmodule
